// File: hdl/bhp_pkg.sv
// ----------------------------------------------------------------------------
// bhp_pkg
// Shared types and constants for the bitmap header parser: field positions
// within the file, the expected identifier and the result status codes.
// ----------------------------------------------------------------------------
package bhp_pkg;

	// Byte offsets of the captured little-endian fields
	localparam logic [5:0] PosId          = 6'd0;
	localparam logic [5:0] PosIdLast      = 6'd1;
	localparam logic [5:0] PosOffset      = 6'd10;
	localparam logic [5:0] PosWidth       = 6'd18;
	localparam logic [5:0] PosHeight      = 6'd22;
	localparam logic [5:0] PosBits        = 6'd28;
	localparam logic [5:0] PosCompression = 6'd30;
	localparam logic [5:0] PosColours     = 6'd46;
	localparam logic [5:0] PosLast        = 6'd49;

	// 'BM' read little-endian
	localparam logic [15:0] HdrIdBm     = 16'h4D42;
	localparam logic [15:0] WantedDepth = 16'd24;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_ID     = 3'd1,
		ST_COMPRESSED = 3'd2,
		ST_PALETTE    = 3'd3,
		ST_DEPTH      = 3'd4
	} status_t;

	typedef struct packed {
		status_t            status;
		logic        [31:0] data_offset;
		logic signed [31:0] width;
		logic signed [31:0] height;
		logic        [15:0] bits_per_pixel;
		logic        [31:0] row_bytes;
	} result_t;

endpackage

// File: hdl/bhp_if.sv
// ----------------------------------------------------------------------------
// bhp_byte_if / bhp_hdr_if
// Valid/ready channels of the bitmap header parser: the incoming byte stream
// and the outgoing parsed header.
// ----------------------------------------------------------------------------
interface bhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       new_file;

	modport source (output valid, output byte_value, output new_file, input ready);
	modport sink (input valid, input byte_value, input new_file, output ready);
endinterface

interface bhp_hdr_if;
	import bhp_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic        [31:0] data_offset;
	logic signed [31:0] width;
	logic signed [31:0] height;
	logic        [15:0] bits_per_pixel;
	logic        [31:0] row_bytes;

	modport source (output valid, output status, output data_offset, output width,
		output height, output bits_per_pixel, output row_bytes, input ready);
	modport sink (input valid, input status, input data_offset, input width,
		input height, input bits_per_pixel, input row_bytes, output ready);
endinterface

// File: hdl/bmp_header_parser.sv
// ----------------------------------------------------------------------------
// bmp_header_parser
// Streaming parser for a bitmap file header with info header. Captures the
// geometry fields as their bytes pass and emits one header transaction.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   note
//  byte_in   in   byte_value[7:0], new_file                 one file byte per transaction
//  hdr_out   out  status, data_offset, width, height,       at most one per file
//                 bits_per_pixel, row_bytes
//
// One byte is taken per cycle while byte_in is ready; byte 49 (or byte 1 on a bad
// identifier) registers the result, into the skid register if the output is held.
// The scanline product bits*width is registered each cycle from the captured
// fields, which settle twenty bytes before it is needed.
// A two-entry output (result register plus skid register) keeps byte_in ready
// while one result waits; byte_in stalls only while the skid register is full.
// After reset the parser ignores bytes until one arrives with new_file set.
module bmp_header_parser (
	input  logic             clk,
	input  logic             arst_n,
	bhp_byte_if.sink         byte_in,
	bhp_hdr_if.source        hdr_out
);
	import bhp_pkg::*;

	logic        [5:0]      pos_q;
	logic                   finished_q;
	logic        [7:0]      id_lo_q;
	logic        [3:0][7:0] offset_q;
	logic        [3:0][7:0] width_q;
	logic        [3:0][7:0] height_q;
	logic        [1:0][7:0] bits_q;
	logic        [3:0][7:0] compression_q;
	logic        [2:0][7:0] colours_q;
	logic        [31:0]     prod_q;

	logic                   out_valid_q;
	logic                   skid_valid_q;
	result_t                out_q;
	result_t                skid_q;

	logic                   accept;
	logic                   out_free;
	logic        [5:0]      pos_eff;
	logic                   active;
	logic                   bad_id;
	logic                   last_byte;
	logic                   new_result;
	logic        [31:0]     colours_full;
	logic        [31:0]     row_bytes;
	result_t                result;

	// Handshake
	assign byte_in.ready = !skid_valid_q;
	assign accept        = byte_in.valid && byte_in.ready;
	assign out_free      = !out_valid_q || hdr_out.ready;

	// Effective position once a new-file flag restarts the parse
	assign pos_eff    = byte_in.new_file ? PosId : pos_q;
	assign active     = byte_in.new_file || !finished_q;
	assign bad_id     = (pos_eff == PosIdLast) && ({byte_in.byte_value, id_lo_q} != HdrIdBm);
	assign last_byte  = (pos_eff == PosLast);
	assign new_result = accept && active && (bad_id || last_byte);

	// Build the result
	assign colours_full = {byte_in.byte_value, colours_q};
	assign row_bytes    = ((prod_q + 32'd31) >> 5) << 2;

	always_comb begin
		result = '0;
		if (bad_id) begin
			result.status = ST_BAD_ID;
		end else begin
			if (compression_q != '0) begin
				result.status = ST_COMPRESSED;
			end else if (colours_full != '0) begin
				result.status = ST_PALETTE;
			end else if (bits_q != WantedDepth) begin
				result.status = ST_DEPTH;
			end else begin
				result.status = ST_OK;
			end
			result.data_offset    = offset_q;
			result.width          = $signed(width_q);
			result.height         = $signed(height_q);
			result.bits_per_pixel = bits_q;
			result.row_bytes      = row_bytes;
		end
	end

	// Advance position and finished flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			finished_q <= 1'b1;
		end else if (accept && active) begin
			if (bad_id || last_byte) begin
				finished_q <= 1'b1;
				pos_q      <= pos_eff;
			end else begin
				finished_q <= 1'b0;
				pos_q      <= pos_eff + 6'd1;
			end
		end
	end

	// Capture header fields lane by lane; clear them on a new file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_lo_q       <= '0;
			offset_q      <= '0;
			width_q       <= '0;
			height_q      <= '0;
			bits_q        <= '0;
			compression_q <= '0;
			colours_q     <= '0;
		end else if (accept && active) begin
			// A new file always lands on byte 0, so id_lo_q is loaded below
			if (byte_in.new_file) begin
				offset_q      <= '0;
				width_q       <= '0;
				height_q      <= '0;
				bits_q        <= '0;
				compression_q <= '0;
				colours_q     <= '0;
			end
			if (pos_eff == PosId) begin
				id_lo_q <= byte_in.byte_value;
			end
			if (pos_eff >= PosOffset && pos_eff < PosOffset + 6'd4) begin
				offset_q[2'(pos_eff - PosOffset)] <= byte_in.byte_value;
			end
			if (pos_eff >= PosWidth && pos_eff < PosWidth + 6'd4) begin
				width_q[2'(pos_eff - PosWidth)] <= byte_in.byte_value;
			end
			if (pos_eff >= PosHeight && pos_eff < PosHeight + 6'd4) begin
				height_q[2'(pos_eff - PosHeight)] <= byte_in.byte_value;
			end
			if (pos_eff >= PosBits && pos_eff < PosBits + 6'd2) begin
				bits_q[1'(pos_eff - PosBits)] <= byte_in.byte_value;
			end
			if (pos_eff >= PosCompression && pos_eff < PosCompression + 6'd4) begin
				compression_q[2'(pos_eff - PosCompression)] <= byte_in.byte_value;
			end
			if (pos_eff >= PosColours && pos_eff < PosColours + 6'd3) begin
				colours_q[2'(pos_eff - PosColours)] <= byte_in.byte_value;
			end
		end
	end

	// Register the scanline bit count, wrapped to 32 bits
	always_ff @(posedge clk) begin
		prod_q <= 32'(bits_q) * width_q;
	end

	// Hold results in the output register, spill to the skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= new_result;
			end
		end else if (new_result) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : result;
		end
		if (!out_free && new_result) begin
			skid_q <= result;
		end
	end

	// Drive the output channel
	assign hdr_out.valid          = out_valid_q;
	assign hdr_out.status         = out_q.status;
	assign hdr_out.data_offset    = out_q.data_offset;
	assign hdr_out.width          = out_q.width;
	assign hdr_out.height         = out_q.height;
	assign hdr_out.bits_per_pixel = out_q.bits_per_pixel;
	assign hdr_out.row_bytes      = out_q.row_bytes;

	// Checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while result register empty");

	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		new_result |=> finished_q)
		else $error("parse not finished after a result");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosLast)
		else $error("byte position beyond last header byte");

	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q && !byte_in.new_file) |-> !new_result)
		else $error("result raised while waiting for a new file");

endmodule
